// ----- sv/lzd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared widths, constants and control types of the LZSS decoder.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int unsigned CodeWidth   = 8;
  localparam int unsigned PixelWidth  = 8;
  localparam int unsigned CountWidth  = 24;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned WindowDepth = 4096;

  // first window position written after a stream start
  localparam logic [11:0] WriteStart = 12'hFEE;
  localparam logic [CountWidth-1:0] PixelReset = 24'd76800;

  localparam logic [4:0] MinMatch  = 5'd3;
  localparam logic [4:0] MaxMatch  = 5'd18;
  localparam logic [3:0] FlagCount = 4'd8;

  // register index of pixel_count
  localparam logic RegPixelCount = 1'b0;

  // window access request from the decoder
  typedef struct packed {
    logic clear;
    logic rd_en;
    logic wr_en;
  } win_ctrl_t;

endpackage

// ----- sv/lzd_in_if.sv -----
// ----------------------------------------------------------------------------
// lzd_in_if
// Compressed byte channel: valid/ready handshake with one code byte per item.
// ----------------------------------------------------------------------------
interface lzd_in_if;
  logic                             valid;
  logic                             ready;
  logic [lzd_pkg::CodeWidth-1:0]    code_byte;
  logic                             stream_start;

  modport source (output valid, code_byte, stream_start, input ready);
  modport sink   (input valid, code_byte, stream_start, output ready);
endinterface

// ----- sv/lzd_out_if.sv -----
// ----------------------------------------------------------------------------
// lzd_out_if
// Decoded byte channel: valid/ready handshake with one pixel per item.
// ----------------------------------------------------------------------------
interface lzd_out_if;
  logic                             valid;
  logic                             ready;
  logic [lzd_pkg::PixelWidth-1:0]   pixel;
  logic                             run_last;
  logic                             frame_end;

  modport source (output valid, pixel, run_last, frame_end, input ready);
  modport sink   (input valid, pixel, run_last, frame_end, output ready);
endinterface

// ----- sv/lzd_window.sv -----
// ----------------------------------------------------------------------------
// lzd_window
// History window memory: one read and one write port, registered read data,
// fill count in place of a clearing pass, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module lzd_window #(
  parameter int unsigned WINDOW_DEPTH = lzd_pkg::WindowDepth,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH),
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lzd_pkg::win_ctrl_t                ctrl_i,
  input  logic [AW-1:0]                     rd_addr_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic [lzd_pkg::PixelWidth-1:0]    wr_data_i,
  output logic [lzd_pkg::PixelWidth-1:0]    rd_data_o
);

  logic [lzd_pkg::PixelWidth-1:0] mem_q [WINDOW_DEPTH];
  logic [lzd_pkg::PixelWidth-1:0] rdata_q;
  logic [lzd_pkg::PixelWidth-1:0] fwd_data_q;
  logic [FW-1:0]                  fill_q, fill_d, fill_base;
  logic                           valid_q, valid_d;
  logic                           fwd_q, fwd_d;
  logic [AW-1:0]                  rd_offset;

  // writes run in order from the start position, so an entry has been
  // written in this stream when its distance from the start is below fill
  assign fill_base = ctrl_i.clear ? '0 : fill_q;
  assign rd_offset = rd_addr_i - AW'(lzd_pkg::WriteStart);

  always_comb begin
    fill_d  = fill_base;
    if (ctrl_i.wr_en && (fill_base != FW'(WINDOW_DEPTH))) begin
      fill_d = fill_base + 1'b1;
    end
    valid_d = FW'(rd_offset) < fill_base;
    fwd_d   = ctrl_i.wr_en && (rd_addr_i == wr_addr_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (ctrl_i.rd_en) begin
        valid_q <= valid_d;
        fwd_q   <= fwd_d;
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (valid_q ? rdata_q : '0);

endmodule

// ----- sv/lzd_decoder.sv -----
// ----------------------------------------------------------------------------
// lzd_decoder
// Token parser and copy sequencer: flag bits, literals and window matches,
// output register and frame byte count.
// ----------------------------------------------------------------------------
module lzd_decoder #(
  parameter int unsigned WINDOW_DEPTH = lzd_pkg::WindowDepth,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lzd_in_if.sink                            in_s,
  lzd_out_if.source                         out_m,
  input  logic [lzd_pkg::CountWidth-1:0]    pixel_count_i,
  output lzd_pkg::win_ctrl_t                win_ctrl_o,
  output logic [AW-1:0]                     win_rd_addr_o,
  output logic [AW-1:0]                     win_wr_addr_o,
  output logic [lzd_pkg::PixelWidth-1:0]    win_wr_data_o,
  input  logic [lzd_pkg::PixelWidth-1:0]    win_rd_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLit  = 2'd1;
  localparam logic [1:0] StCopy = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [AW-1:0]                    wp_q, wp_d, wp_e;
  logic [AW-1:0]                    src_q, src_d;
  logic [4:0]                       len_q, len_d;
  logic [7:0]                       bits_q, bits_d, bits_e;
  logic [3:0]                       left_q, left_d, left_e;
  logic [7:0]                       pend_q, pend_d, pend_e;
  logic                             phase_q, phase_d, phase_e;
  logic [lzd_pkg::CountWidth-1:0]   count_q, count_d, count_e, count_inc;
  logic                             fin_q, fin_d, fin_e;
  logic [lzd_pkg::PixelWidth-1:0]   lit_q, lit_d;
  logic                             out_valid_q, out_valid_d;
  logic [lzd_pkg::PixelWidth-1:0]   pixel_q, pixel_d, emit_byte;
  logic                             run_last_q, run_last_d;
  logic                             frame_end_q, frame_end_d;
  logic                             out_free, accept, start, done;
  logic [lzd_pkg::CodeWidth-1:0]    code;
  lzd_pkg::win_ctrl_t               win_ctrl;
  logic [AW-1:0]                    rd_addr;

  assign in_s.ready = (state_q == StIdle);
  assign accept     = in_s.valid && in_s.ready;
  assign start      = in_s.stream_start;
  assign code       = in_s.code_byte;
  assign out_free   = !out_valid_q || out_m.ready;

  // state as seen after an optional restart by this item
  assign wp_e    = start ? AW'(lzd_pkg::WriteStart) : wp_q;
  assign bits_e  = start ? '0 : bits_q;
  assign left_e  = start ? '0 : left_q;
  assign pend_e  = start ? '0 : pend_q;
  assign phase_e = start ? 1'b0 : phase_q;
  assign count_e = start ? '0 : count_q;
  assign fin_e   = start ? 1'b0 : fin_q;

  assign emit_byte = (state_q == StLit) ? lit_q : win_rd_data_i;
  assign count_inc = count_q + 1'b1;
  assign done      = count_inc >= pixel_count_i;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    src_d       = src_q;
    len_d       = len_q;
    bits_d      = bits_q;
    left_d      = left_q;
    pend_d      = pend_q;
    phase_d     = phase_q;
    count_d     = count_q;
    fin_d       = fin_q;
    lit_d       = lit_q;
    pixel_d     = pixel_q;
    run_last_d  = run_last_q;
    frame_end_d = frame_end_q;
    out_valid_d = out_valid_q && !out_m.ready;
    win_ctrl    = '0;
    rd_addr     = src_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          win_ctrl.clear = start;
          wp_d    = wp_e;
          bits_d  = bits_e;
          left_d  = left_e;
          pend_d  = pend_e;
          phase_d = phase_e;
          count_d = count_e;
          fin_d   = fin_e;
          if (!fin_e) begin
            if (count_e >= pixel_count_i) begin
              fin_d = 1'b1;
            end else if (phase_e) begin
              // second byte of a match: start the copy with the first read
              phase_d        = 1'b0;
              rd_addr        = AW'({code[7:4], pend_e});
              win_ctrl.rd_en = 1'b1;
              src_d          = rd_addr + 1'b1;
              len_d          = {1'b0, code[3:0]} + lzd_pkg::MinMatch;
              state_d        = StCopy;
            end else if (left_e == '0) begin
              bits_d = code;
              left_d = lzd_pkg::FlagCount;
            end else begin
              left_d = left_e - 1'b1;
              bits_d = bits_e >> 1;
              if (bits_e[0]) begin
                lit_d   = code;
                state_d = StLit;
              end else begin
                pend_d  = code;
                phase_d = 1'b1;
              end
            end
          end
        end
      end
      StLit, StCopy: begin
        if (out_free) begin
          win_ctrl.wr_en = 1'b1;
          wp_d           = wp_q + 1'b1;
          count_d        = count_inc;
          fin_d          = fin_q || done;
          out_valid_d    = 1'b1;
          pixel_d        = emit_byte;
          frame_end_d    = done;
          run_last_d     = (state_q == StLit) || done || (len_q == 5'd1);
          if ((state_q == StLit) || done || (len_q == 5'd1)) begin
            state_d = StIdle;
          end else begin
            win_ctrl.rd_en = 1'b1;
            src_d          = src_q + 1'b1;
            len_d          = len_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= AW'(lzd_pkg::WriteStart);
      bits_q      <= '0;
      left_q      <= '0;
      pend_q      <= '0;
      phase_q     <= 1'b0;
      count_q     <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      bits_q      <= bits_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    lit_q       <= lit_d;
    pixel_q     <= pixel_d;
    run_last_q  <= run_last_d;
    frame_end_q <= frame_end_d;
  end

  assign out_m.valid     = out_valid_q;
  assign out_m.pixel     = pixel_q;
  assign out_m.run_last  = run_last_q;
  assign out_m.frame_end = frame_end_q;

  assign win_ctrl_o    = win_ctrl;
  assign win_rd_addr_o = rd_addr;
  assign win_wr_addr_o = wp_q;
  assign win_wr_data_o = emit_byte;

  // a finished frame never leaves a literal or copy in flight
  a_no_work_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fin_q && (state_q != StIdle)))
    else $error("decoder busy after frame end");

  a_copy_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy) |-> ((len_q != '0) && (len_q <= lzd_pkg::MaxMatch)))
    else $error("copy length out of range");

  a_frame_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && frame_end_q) |-> run_last_q)
    else $error("frame end without run end");

  a_wp_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_ctrl.wr_en |=> (wp_q == AW'($past(wp_q) + 1'b1)))
    else $error("write pointer did not advance");

endmodule

// ----- sv/lzss_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// lzss_decompressor_unit
// LZSS decoder with a 4 KiB history window and an APB pixel count register.
// ----------------------------------------------------------------------------
// Compressed bytes enter one item at a time on in_i and decoded bytes leave on
// out_o. A flag byte or the first byte of a match gives no output; a literal
// gives one byte; the second byte of a match starts a copy of L = 3 to 18
// bytes, one window read and one write per copied byte, since the history
// window has one read and one write port. No new byte is taken until the
// literal or copy is done. Output stalls hold the copy in place. A stream
// start clears the window at once through a fill count, so there is no
// clearing pass. pixel_count at address 0 sets how many bytes make a frame;
// after that input is dropped until the next stream start.
module lzss_decompressor_unit #(
  parameter int unsigned WINDOW_DEPTH = lzd_pkg::WindowDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lzd_in_if.sink                            in_i,
  lzd_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lzd_pkg::AddrWidth-1:0]     paddr,
  input  logic [lzd_pkg::DataWidth-1:0]     pwdata,
  output logic [lzd_pkg::DataWidth-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  logic [lzd_pkg::CountWidth-1:0]   pixel_count_q, pixel_count_d;
  lzd_pkg::win_ctrl_t               win_ctrl;
  logic [AW-1:0]                    win_rd_addr, win_wr_addr;
  logic [lzd_pkg::PixelWidth-1:0]   win_wr_data, win_rd_data;
  logic                             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lzd_pkg::RegPixelCount);

  always_comb begin
    pixel_count_d = pixel_count_q;
    if (psel && penable && pwrite && reg_sel) begin
      pixel_count_d = pwdata[lzd_pkg::CountWidth-1:0];
    end
    prdata = reg_sel ? lzd_pkg::DataWidth'(pixel_count_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= lzd_pkg::PixelReset;
    end else begin
      pixel_count_q <= pixel_count_d;
    end
  end

  lzd_decoder #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_s          (in_i),
    .out_m         (out_o),
    .pixel_count_i (pixel_count_q),
    .win_ctrl_o    (win_ctrl),
    .win_rd_addr_o (win_rd_addr),
    .win_wr_addr_o (win_wr_addr),
    .win_wr_data_o (win_wr_data),
    .win_rd_data_i (win_rd_data)
  );

  lzd_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .rd_addr_i (win_rd_addr),
    .wr_addr_i (win_wr_addr),
    .wr_data_i (win_wr_data),
    .rd_data_o (win_rd_data)
  );

endmodule

// ----- tb/lzd_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzd_tb_pkg
// Pixel scoreboard for the LZSS decoder: decodes every accepted code byte on
// its own copy of the window and checks decoded pixels in order against it.
// ----------------------------------------------------------------------------
package lzd_tb_pkg;

  import lzd_pkg::*;

  typedef struct packed {
    logic [PixelWidth-1:0] pixel;
    logic                  run_last;
    logic                  frame_end;
  } pixel_item_t;

  typedef enum logic {
    TokenNext,
    MatchHigh
  } token_phase_e;

  localparam int unsigned ReportLimit = 10;

  class pixel_scoreboard;
    logic [7:0]            window [WindowDepth];
    logic [11:0]           wr_pos;
    logic [7:0]            flag_bits;
    logic [3:0]            flags_left;
    logic [7:0]            match_low;
    token_phase_e          phase;
    logic [CountWidth-1:0] emitted;
    logic [CountWidth-1:0] pixel_limit;
    bit                    frame_done;
    pixel_item_t           pixels_due[$];
    int unsigned           errors;

    function new();
      restart();
      pixel_limit = PixelReset;
      errors      = 0;
    endfunction

    function void restart();
      foreach (window[i]) window[i] = '0;
      wr_pos     = WriteStart;
      flag_bits  = '0;
      flags_left = '0;
      match_low  = '0;
      phase      = TokenNext;
      emitted    = '0;
      frame_done = 1'b0;
    endfunction

    function void set_limit(logic [CountWidth-1:0] value);
      pixel_limit = value;
    endfunction

    // stores one decoded byte, returns 1 when it completes the frame
    function bit store_pixel(logic [7:0] b);
      window[wr_pos] = b;
      wr_pos         = wr_pos + 12'd1;
      emitted        = emitted + 1'b1;
      if (emitted >= pixel_limit) begin
        frame_done = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void decode_code_byte(logic [7:0] code, logic start);
      pixel_item_t item;
      logic [11:0] src;
      int          len;
      if (start) restart();
      if (frame_done) return;
      if (emitted >= pixel_limit) begin
        frame_done = 1'b1;
        return;
      end
      if (phase == MatchHigh) begin
        phase = TokenNext;
        src   = {code[7:4], match_low};
        len   = int'(code[3:0]) + int'(MinMatch);
        // byte by byte so an overlapping copy sees its own output
        for (int k = 0; k < len; k++) begin
          item.pixel     = window[src];
          item.frame_end = store_pixel(item.pixel);
          item.run_last  = item.frame_end || (k == len - 1);
          pixels_due.push_back(item);
          src = src + 12'd1;
          if (item.frame_end) break;
        end
      end else if (flags_left == '0) begin
        flag_bits  = code;
        flags_left = FlagCount;
      end else begin
        flags_left = flags_left - 4'd1;
        if (flag_bits[0]) begin
          item.pixel     = code;
          item.frame_end = store_pixel(code);
          item.run_last  = 1'b1;
          pixels_due.push_back(item);
        end else begin
          match_low = code;
          phase     = MatchHigh;
        end
        flag_bits = flag_bits >> 1;
      end
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= ReportLimit) $display("mismatch: %s", msg);
    endfunction

    function void check_pixel(pixel_item_t got);
      pixel_item_t want;
      if (pixels_due.size() == 0) begin
        note_error($sformatf("unexpected pixel %02h run_last %0b frame_end %0b",
                             got.pixel, got.run_last, got.frame_end));
        return;
      end
      want = pixels_due.pop_front();
      if (got !== want) begin
        note_error($sformatf({"expected pixel %02h run_last %0b frame_end %0b, ",
                              "got pixel %02h run_last %0b frame_end %0b"},
                             want.pixel, want.run_last, want.frame_end,
                             got.pixel, got.run_last, got.frame_end));
      end
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the LZSS decoder: directed token streams for the corner cases,
// then random flag groups with back references near the write pointer, with
// random pixel counts, idle gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

  import lzd_pkg::*;
  import lzd_tb_pkg::*;

  localparam int unsigned     ResetCycles    = 12;
  localparam int unsigned     RandomItems    = 380;
  localparam int unsigned     DrainCycles    = 40;
  localparam int unsigned     HoldCycles     = 400;
  localparam longint unsigned CycleLimit     = 1_000_000;
  localparam logic [AddrWidth-1:0] PixelCountAddr = {RegPixelCount, 2'b00};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  lzd_in_if  in_if ();
  lzd_out_if out_if ();

  lzss_decompressor_unit uut (
    .clk_i,
    .rst_ni,
    .in_i    (in_if),
    .out_o   (out_if),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  pixel_scoreboard sb;
  longint unsigned cycles = 0;
  int unsigned     items_sent;
  bit              quiet_in;
  bit              hold_req;
  bit              hold_done;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_pixel({out_if.pixel, out_if.run_last, out_if.frame_end});
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // receiver side
  initial begin
    int unsigned g;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if ($urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        g = idle_len();
        if (g != 0) begin
          out_if.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_code(input logic [7:0] code, input logic start);
    int unsigned g;
    bit          ignored;
    in_if.valid        <= 1'b1;
    in_if.code_byte    <= code;
    in_if.stream_start <= start;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    ignored = sb.frame_done && !start;
    sb.decode_code_byte(code, start);
    if (!ignored) items_sent++;
    g = quiet_in ? 0 : idle_len();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // drop valid, wait for every pending pixel, then let a copy in flight settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic read_pixel_count();
    logic [DataWidth-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PixelCountAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[CountWidth-1:0] !== sb.pixel_limit) begin
      sb.note_error($sformatf("pixel_count read %06h, expected %06h",
                              got[CountWidth-1:0], sb.pixel_limit));
    end
    @(posedge clk_i);
  endtask

  task automatic program_pixel_count(input logic [CountWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PixelCountAddr;
    pwdata  <= {8'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_limit(value);
    @(posedge clk_i);
    read_pixel_count();
  endtask

  // one flag byte and its eight tokens, with an occasional stray byte
  task automatic send_group(input logic start);
    logic [7:0]  flags;
    logic [11:0] src;
    flags = 8'($urandom);
    send_code(flags, start);
    for (int k = 0; k < 8; k++) begin
      if (sb.frame_done || items_sent >= RandomItems) return;
      if ($urandom_range(0, 19) == 0) begin
        send_code(8'($urandom), $urandom_range(0, 3) == 0);
      end else if (flags[k]) begin
        send_code(8'($urandom), 1'b0);
      end else begin
        // mostly recent history so copies carry real data
        if ($urandom_range(0, 9) < 7) src = sb.wr_pos - 12'($urandom_range(1, 48));
        else src = 12'($urandom);
        send_code(src[7:0], 1'b0);
        send_code({src[11:8], 4'($urandom)}, 1'b0);
      end
    end
  endtask

  initial begin
    int unsigned           phase_len;
    int unsigned           start_items;
    int unsigned           r;
    logic [CountWidth-1:0] count;
    logic                  fresh;
    sb                 = new();
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.code_byte    = '0;
    in_if.stream_start = 1'b0;
    quiet_in           = 1'b0;
    hold_req           = 1'b0;
    hold_done          = 1'b0;
    items_sent         = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_pixel_count();

    // literals 00 and ff, overlapping copy, copies from both window ends
    send_code(8'hD3, 1'b1);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'hEF, 1'b0);
    send_code(8'hF0, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h0F, 1'b0);
    send_code(8'hA5, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h5A, 1'b0);
    send_code(8'h3C, 1'b0);
    // restart between the two bytes of a match
    send_code(8'h00, 1'b1);
    send_code(8'h12, 1'b0);
    send_code(8'hFE, 1'b1);
    wait_idle();

    // long copy cut off at the frame end, then bytes after the end
    program_pixel_count(24'd5);
    send_code(8'h01, 1'b1);
    send_code(8'h77, 1'b0);
    send_code(8'h34, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h99, 1'b0);
    send_code(8'h42, 1'b0);
    wait_idle();

    program_pixel_count(24'd1);
    send_code(8'hFF, 1'b1);
    send_code(8'h80, 1'b0);
    wait_idle();

    // limit lowered below the pixels already out
    program_pixel_count(24'd100);
    send_code(8'hFF, 1'b1);
    send_code(8'h01, 1'b0);
    send_code(8'h02, 1'b0);
    send_code(8'h03, 1'b0);
    wait_idle();
    program_pixel_count(24'd2);
    send_code(8'h04, 1'b0);
    send_code(8'h05, 1'b0);
    wait_idle();

    items_sent = 0;
    for (int p = 0; items_sent < RandomItems; p++) begin
      r = $urandom_range(0, 19);
      if (r < 12) count = 24'($urandom_range(1, 300));
      else if (r < 14) count = 24'($urandom_range(301, 3000));
      else if (r < 16) count = 24'hFFFFFF;
      else if (r < 17) count = 24'd1;
      else if (r < 18) count = PixelReset;
      else count = 24'($urandom_range(1, 60));
      fresh     = (p == 0) || ($urandom_range(0, 4) != 0);
      quiet_in  = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(15, 70);
      if (p == 1) begin
        // keep offering items while the receiver holds off
        count     = 24'hFFFFFF;
        fresh     = 1'b1;
        quiet_in  = 1'b1;
        phase_len = 70;
        hold_req  = 1'b1;
      end
      program_pixel_count(count);
      start_items = items_sent;
      send_group(fresh);
      while (!sb.frame_done && items_sent - start_items < phase_len &&
             items_sent < RandomItems) begin
        send_group(1'b0);
      end
      if (sb.frame_done) repeat ($urandom_range(0, 2)) send_code(8'($urandom), 1'b0);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
